// File: design/wfhc_pkg.sv
// Shared types and constants for the wire frame header checker.
// No dependencies; used by every module in the design folder.

package wfhc_pkg;

   localparam int COUNT_W = 33;

   // Header layout and limits
   localparam logic [COUNT_W-1:0] HEADER_LEN   = 33'd20;
   localparam logic [15:0]        WIRE_VERSION = 16'd1;
   localparam logic [7:0]         DIR_REQUEST  = 8'd0;
   localparam logic [7:0]         DIR_RESPONSE = 8'd1;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FRAME     = 3'd1;
   localparam logic [2:0] ST_VERSION   = 3'd2;
   localparam logic [2:0] ST_DIRECTION = 3'd3;
   localparam logic [2:0] ST_KIND      = 3'd4;
   localparam logic [2:0] ST_ID        = 3'd5;
   localparam logic [2:0] ST_LIMIT     = 3'd6;

   // Register indexes
   localparam logic [1:0] CSR_MAX_PAYLOAD     = 2'd0;
   localparam logic [1:0] CSR_KIND_MIN        = 2'd1;
   localparam logic [1:0] CSR_KIND_MAX        = 2'd2;
   localparam logic [1:0] CSR_REQUIRE_REQUEST = 2'd3;

   // Register reset values
   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;
   localparam logic [7:0]  KIND_MIN_RESET    = 8'd0;
   localparam logic [7:0]  KIND_MAX_RESET    = 8'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  direction;
      logic [7:0]  kind;
      logic [63:0] frame_id;
      logic [31:0] body_size;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] max_payload;
      logic [7:0]  kind_min;
      logic [7:0]  kind_max;
      logic        require_request;
   } cfg_type;

   // Magic bytes, first on the wire at index 0
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h50;
         2'd1:    b = 8'h53;
         2'd2:    b = 8'h41;
         default: b = 8'h50;
      endcase
      return b;
   endfunction

endpackage

// File: design/wfhc_parser.sv
// Per-frame parse state and header checks for the frame header checker.
// Depends on wfhc_pkg.

module wfhc_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  wfhc_pkg::req_word_type byte_word,
   input  wfhc_pkg::cfg_type     cfg,
   output logic                  result_valid,
   output wfhc_pkg::rsp_word_type result_word
);

   logic [wfhc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [2:0]  error_ff, error_in;
   logic [15:0] version_ff, version_in;
   logic [7:0]  direction_ff, direction_in;
   logic [7:0]  kind_ff, kind_in;
   logic [63:0] id_ff, id_in;
   logic [31:0] size_ff, size_in;

   logic [2:0]  flag_code;
   logic [2:0]  status;
   logic [4:0]  hdr_pos;
   logic        in_header;
   logic [7:0]  b;

   assign b         = byte_word.data_byte;
   assign hdr_pos   = count_ff[4:0];
   assign in_header = count_ff < wfhc_pkg::HEADER_LEN;

   always_comb begin
      version_in   = version_ff;
      direction_in = direction_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      size_in      = size_ff;
      flag_code    = wfhc_pkg::ST_OK;
      if (in_header) begin
         if (hdr_pos inside {[5'd0:5'd3]}) begin
            if (b != wfhc_pkg::magic_byte(hdr_pos[1:0])) flag_code = wfhc_pkg::ST_FRAME;
         end else if (hdr_pos inside {[5'd4:5'd5]}) begin
            version_in = {version_ff[7:0], b};
            if (hdr_pos == 5'd5 && version_in != wfhc_pkg::WIRE_VERSION)
               flag_code = wfhc_pkg::ST_VERSION;
         end else if (hdr_pos == 5'd6) begin
            direction_in = b;
            if (b > wfhc_pkg::DIR_RESPONSE) flag_code = wfhc_pkg::ST_DIRECTION;
         end else if (hdr_pos == 5'd7) begin
            kind_in = b;
            if (b < cfg.kind_min || b > cfg.kind_max) flag_code = wfhc_pkg::ST_KIND;
         end else if (hdr_pos inside {[5'd8:5'd15]}) begin
            id_in = {id_ff[55:0], b};
            if (hdr_pos == 5'd15 && id_in == 64'd0) flag_code = wfhc_pkg::ST_ID;
         end else begin
            size_in = {size_ff[23:0], b};
            if (hdr_pos == 5'd19 && size_in > cfg.max_payload) flag_code = wfhc_pkg::ST_LIMIT;
         end
      end
   end

   // only the first failing check is kept
   assign error_in = (error_ff == wfhc_pkg::ST_OK) ? flag_code : error_ff;
   // saturating byte count
   assign count_in = (&count_ff) ? count_ff : count_ff + {{(wfhc_pkg::COUNT_W-1){1'b0}}, 1'b1};

   always_comb begin
      if (count_in < wfhc_pkg::HEADER_LEN) begin
         status = wfhc_pkg::ST_FRAME;
      end else if (error_in != wfhc_pkg::ST_OK) begin
         status = error_in;
      end else if (count_in != wfhc_pkg::HEADER_LEN + {1'b0, size_in}) begin
         status = wfhc_pkg::ST_FRAME;
      end else if (cfg.require_request && direction_in != wfhc_pkg::DIR_REQUEST) begin
         status = wfhc_pkg::ST_DIRECTION;
      end else begin
         status = wfhc_pkg::ST_OK;
      end
   end

   assign result_valid          = byte_valid & byte_word.last_byte;
   assign result_word.status    = status;
   assign result_word.direction = direction_in;
   assign result_word.kind      = kind_in;
   assign result_word.frame_id  = id_in;
   assign result_word.body_size = size_in;

   always_ff @(posedge clock) begin
      if (reset || (byte_valid && byte_word.last_byte)) begin
         count_ff     <= '0;
         error_ff     <= wfhc_pkg::ST_OK;
         version_ff   <= '0;
         direction_ff <= '0;
         kind_ff      <= '0;
         id_ff        <= '0;
         size_ff      <= '0;
      end else if (byte_valid) begin
         count_ff     <= count_in;
         error_ff     <= error_in;
         version_ff   <= version_in;
         direction_ff <= direction_in;
         kind_ff      <= kind_in;
         id_ff        <= id_in;
         size_ff      <= size_in;
      end
   end

endmodule

// File: design/wfhc_out_reg.sv
// Result register between the parser and the rsp_ channel.
// Depends on wfhc_pkg.

module wfhc_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  wfhc_pkg::rsp_word_type load_word,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output wfhc_pkg::rsp_word_type rsp_word
);

   logic                   valid_ff;
   wfhc_pkg::rsp_word_type word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// File: design/wire_frame_header_checker.sv
// Top level of the wire frame header checker.
// Depends on wfhc_pkg, wfhc_parser and wfhc_out_reg.

// Takes a frame one byte per req_ word, last byte flagged, and gives one rsp_
// word per frame in the cycle after its last byte is taken. Sustained rate is
// one byte per clock: each byte only updates the byte counter and shifts into
// the header field it belongs to, so the parse state registers close the loop
// on every byte. Results sit in one output register; while it is full and not
// being drained, ordinary bytes are still taken and only a last byte waits.
// The CSRs are written with csr_write_enable and take effect at once; change
// them only between frames.
//   index 0  max_payload     (32 bits, reset 1048576)
//   index 1  kind_min        (8 bits,  reset 0)
//   index 2  kind_max        (8 bits,  reset 6)
//   index 3  require_request (1 bit,   reset 0)
// Status: 0 ok, 1 bad frame (short, bad magic, or length mismatch), 2 version,
// 3 direction, 4 kind, 5 zero id, 6 payload over limit. 1 if short, else first failure wins.

module wire_frame_header_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  wfhc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output wfhc_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_write_data
);

   wfhc_pkg::cfg_type      cfg_ff;
   logic                   byte_fire;
   logic                   result_valid;
   wfhc_pkg::rsp_word_type result_word;

   // CSR bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload     <= wfhc_pkg::MAX_PAYLOAD_RESET;
         cfg_ff.kind_min        <= wfhc_pkg::KIND_MIN_RESET;
         cfg_ff.kind_max        <= wfhc_pkg::KIND_MAX_RESET;
         cfg_ff.require_request <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            wfhc_pkg::CSR_MAX_PAYLOAD:     cfg_ff.max_payload     <= csr_write_data;
            wfhc_pkg::CSR_KIND_MIN:        cfg_ff.kind_min        <= csr_write_data[7:0];
            wfhc_pkg::CSR_KIND_MAX:        cfg_ff.kind_max        <= csr_write_data[7:0];
            wfhc_pkg::CSR_REQUIRE_REQUEST: cfg_ff.require_request <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // a last byte needs room in the result register; other bytes never stall
   assign req_ready = !req_word.last_byte || !rsp_valid || rsp_ready;
   assign byte_fire = req_valid && req_ready;

   wfhc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (byte_fire),
      .byte_word    (req_word),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result_word  (result_word)
   );

   wfhc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .load_word (result_word),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

// File: design/wfhc_checker.sv
// Port-level checks for wire_frame_header_checker, attached by bind.
// Depends on wfhc_pkg and the top level's ports.

module wfhc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input wfhc_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input wfhc_pkg::rsp_word_type rsp_word
);

   logic last_fire;
   assign last_fire = req_valid && req_ready && req_word.last_byte;

   // a result that is not taken holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // every accepted last byte yields a result next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      last_fire |=> rsp_valid)
      else $error("no result after last byte");

   // a fresh result only follows an accepted last byte
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> $past(last_fire))
      else $error("result without a last byte");

   // an ok report carries a legal direction and a nonzero id
   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == wfhc_pkg::ST_OK |->
         rsp_word.frame_id != 64'd0 && rsp_word.direction <= wfhc_pkg::DIR_RESPONSE)
      else $error("ok status with bad header fields");

endmodule

bind wire_frame_header_checker wfhc_checker u_wfhc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// File: tb/tb_top.sv
// Self-checking bench for wire_frame_header_checker: byte frames in, one report per frame out.
// Needs wfhc_pkg for the word types, status codes and register indexes, and the DUT.

module tb_top;

   localparam logic [31:0] FRAME_MAGIC   = 32'h50534150;  // first byte on the wire at the top
   localparam logic [wfhc_pkg::COUNT_W-1:0] COUNT_TOP = '1;  // byte counter sticks here
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          SETTLE_CYCLES = 4;             // report lands in the cycle after the last byte
   localparam int          PHASE_BYTES   = 230;

   typedef enum logic [2:0] {
      SINK_OPEN    = 3'b001,
      SINK_CHOPPY  = 3'b010,
      SINK_BLOCKED = 3'b100
   } sink_mode_type;

   // ---------------------------------------------------------------- DUT signals
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   wfhc_pkg::req_word_type req_word         = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   wfhc_pkg::rsp_word_type rsp_word;
   logic                   csr_write_enable = 1'b0;
   logic [1:0]             csr_index        = wfhc_pkg::CSR_MAX_PAYLOAD;
   logic [31:0]            csr_write_data   = '0;

   wire_frame_header_checker uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- bench state
   wfhc_pkg::req_word_type byte_q[$];      // bytes waiting to be offered
   wfhc_pkg::rsp_word_type report_q[$];    // reports owed by the block, oldest first
   logic          req_took   = 1'b0;
   int            burst_left = 0;
   int            gap_left   = 0;
   int            sink_left  = 0;
   sink_mode_type sink_mode  = SINK_OPEN;

   int            faults        = 0;
   int            cycles        = 0;
   int            bytes_queued  = 0;
   int            bytes_taken   = 0;
   int            frames_queued = 0;
   int            reports       = 0;
   int            settings      = 1;   // reset values count as the first setting
   int            status_hits[0:7] = '{default: 0};

   // Register copy, kept in step with every CSR write
   logic [31:0]   lim_payload = wfhc_pkg::MAX_PAYLOAD_RESET;
   logic [7:0]    kind_lo     = wfhc_pkg::KIND_MIN_RESET;
   logic [7:0]    kind_hi     = wfhc_pkg::KIND_MAX_RESET;
   logic          req_only    = 1'b0;

   // Frame parse copy: cleared after every report
   logic [wfhc_pkg::COUNT_W-1:0] frame_pos = '0;
   logic [2:0]         first_fault = wfhc_pkg::ST_OK;
   logic [15:0]        ver_shift   = '0;
   logic [7:0]         dir_seen    = '0;
   logic [7:0]         kind_seen   = '0;
   logic [63:0]        id_shift    = '0;
   logic [31:0]        size_shift  = '0;

   // ---------------------------------------------------------------- frame parser copy
   // Only the first failing header check is kept.
   task automatic keep_first(input logic [2:0] code);
      if (first_fault == wfhc_pkg::ST_OK)
         first_fault = code;
   endtask

   // Fold one accepted byte into the parse state; on a last byte queue the report.
   task automatic track_byte(input wfhc_pkg::req_word_type w);
      logic [wfhc_pkg::COUNT_W-1:0] pos;
      logic [wfhc_pkg::COUNT_W-1:0] total;
      logic [2:0]             st;
      wfhc_pkg::rsp_word_type r;
      pos = frame_pos;
      bytes_taken++;
      if (pos < 4) begin
         if (w.data_byte != FRAME_MAGIC[31 - 8*pos[1:0] -: 8])
            keep_first(wfhc_pkg::ST_FRAME);
      end else if (pos < 6) begin
         ver_shift = {ver_shift[7:0], w.data_byte};
         if (pos == 5 && ver_shift != wfhc_pkg::WIRE_VERSION)
            keep_first(wfhc_pkg::ST_VERSION);
      end else if (pos == 6) begin
         dir_seen = w.data_byte;
         if (w.data_byte > wfhc_pkg::DIR_RESPONSE)
            keep_first(wfhc_pkg::ST_DIRECTION);
      end else if (pos == 7) begin
         kind_seen = w.data_byte;
         if (w.data_byte < kind_lo || w.data_byte > kind_hi)
            keep_first(wfhc_pkg::ST_KIND);
      end else if (pos < 16) begin
         id_shift = {id_shift[55:0], w.data_byte};
         if (pos == 15 && id_shift == '0)
            keep_first(wfhc_pkg::ST_ID);
      end else if (pos < wfhc_pkg::HEADER_LEN) begin
         size_shift = {size_shift[23:0], w.data_byte};
         if (pos == 19 && size_shift > lim_payload)
            keep_first(wfhc_pkg::ST_LIMIT);
      end
      // saturating count; payload bytes only move the counter
      total     = (pos == COUNT_TOP) ? pos : pos + 1'b1;
      frame_pos = total;
      if (w.last_byte) begin
         if (total < wfhc_pkg::HEADER_LEN)
            st = wfhc_pkg::ST_FRAME;
         else if (first_fault != wfhc_pkg::ST_OK)
            st = first_fault;
         else if ({1'b0, total} != {1'b0, wfhc_pkg::HEADER_LEN} + {2'b00, size_shift})
            st = wfhc_pkg::ST_FRAME;
         else if (req_only && dir_seen != wfhc_pkg::DIR_REQUEST)
            st = wfhc_pkg::ST_DIRECTION;
         else
            st = wfhc_pkg::ST_OK;
         r.status    = st;
         r.direction = dir_seen;
         r.kind      = kind_seen;
         r.frame_id  = id_shift;
         r.body_size = size_shift;
         report_q.insert(report_q.size(), r);
         frame_pos   = '0;
         first_fault = wfhc_pkg::ST_OK;
         ver_shift   = '0;
         dir_seen    = '0;
         kind_seen   = '0;
         id_shift    = '0;
         size_shift  = '0;
      end
   endtask

   // Compare a taken report against the oldest one owed, field by field.
   task automatic check_report(input wfhc_pkg::rsp_word_type got);
      wfhc_pkg::rsp_word_type want;
      if (report_q.size() == 0) begin
         $display("%0t: report with none expected: got %h", $time, got);
         faults++;
      end else begin
         want = report_q.pop_front();
         reports++;
         status_hits[want.status]++;
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            faults++;
         end
         if (got.direction !== want.direction) begin
            $display("%0t: direction expected %h got %h", $time, want.direction, got.direction);
            faults++;
         end
         if (got.kind !== want.kind) begin
            $display("%0t: kind expected %h got %h", $time, want.kind, got.kind);
            faults++;
         end
         if (got.frame_id !== want.frame_id) begin
            $display("%0t: frame id expected %h got %h", $time, want.frame_id,
                     got.frame_id);
            faults++;
         end
         if (got.body_size !== want.body_size) begin
            $display("%0t: body size expected %h got %h", $time, want.body_size,
                     got.body_size);
            faults++;
         end
      end
   endtask

   // ---------------------------------------------------------------- monitor
   // Everything is sampled at the rising edge. Output side first: a report
   // taken at this edge can never belong to a byte taken at the same edge.
   always @(posedge clock) begin
      req_took <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_report(rsp_word);
         if (req_valid && req_ready)
            track_byte(req_word);
      end
   end

   // ---------------------------------------------------------------- byte driver
   // Changes only at the falling edge. Works in bursts; each burst opens with
   // an optional gap, and about a third of bursts run with no gap at all.
   // A word stays up, unchanged, until the monitor saw it taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (byte_q.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            req_word  <= byte_q.pop_front();
            req_valid <= 1'b1;
            burst_left--;
         end
      end
   end

   // ---------------------------------------------------------------- report sink
   // Runs of open, choppy or fully blocked ready.
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_left = $urandom_range(1, 24);
         case ($urandom_range(0, 3))
            0, 1:    sink_mode = SINK_OPEN;
            2:       sink_mode = SINK_CHOPPY;
            default: sink_mode = SINK_BLOCKED;
         endcase
      end
      sink_left--;
      case (sink_mode)
         SINK_OPEN:   rsp_ready <= 1'b1;
         SINK_CHOPPY: rsp_ready <= ($urandom_range(0, 1) != 0);
         default:     rsp_ready <= 1'b0;
      endcase
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports still owed", cycles, report_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   // Queue one frame of len bytes: header fields big-endian, then random payload.
   task automatic queue_frame(input logic [31:0] magic, input logic [15:0] ver,
                              input logic [7:0] dir, input logic [7:0] kind,
                              input logic [63:0] id, input logic [31:0] size,
                              input int unsigned len);
      logic [159:0] hdr;
      wfhc_pkg::req_word_type w;
      hdr = {magic, ver, dir, kind, id, size};
      for (int unsigned i = 0; i < len; i++) begin
         w.data_byte = (i < 20) ? hdr[159 - 8*i -: 8] : 8'($urandom_range(0, 255));
         w.last_byte = (i == len - 1);
         byte_q.insert(byte_q.size(), w);
         bytes_queued++;
      end
      frames_queued++;
   endtask

   // Mostly well-formed frames under the current registers; the rest carry
   // one broken field, a bad length, or are pure noise.
   task automatic queue_random_frame();
      logic [31:0]  magic;
      logic [15:0]  ver;
      logic [7:0]   dir;
      logic [7:0]   kind;
      logic [63:0]  id;
      logic [31:0]  size;
      int unsigned  len;
      int unsigned  pick;
      magic = FRAME_MAGIC;
      ver   = wfhc_pkg::WIRE_VERSION;
      dir   = 8'($urandom_range(0, 1));
      kind  = (kind_lo <= kind_hi) ? 8'($urandom_range(kind_hi, kind_lo))
                                   : 8'($urandom_range(0, 255));
      id    = {$urandom, $urandom};
      if (id == '0)
         id = 64'd1;
      size  = $urandom_range(0, 12);
      len   = 20 + size;
      pick  = $urandom_range(0, 99);
      if (pick < 60) begin
         // left well-formed
      end else if (pick < 66) begin
         magic = magic ^ (32'd1 << $urandom_range(0, 31));
      end else if (pick < 71) begin
         ver = 16'($urandom);
      end else if (pick < 76) begin
         dir = 8'($urandom_range(2, 255));
      end else if (pick < 81) begin
         kind = 8'($urandom_range(0, 255));
      end else if (pick < 85) begin
         id = '0;
      end else if (pick < 89) begin
         size = $urandom;                      // declared size no longer matches length
      end else if (pick < 93) begin
         len = $urandom_range(1, 19);          // cut short inside the header
      end else if (pick < 96) begin
         len = $urandom_range(20, 20 + size + 6);
      end else begin
         magic = $urandom;
         ver   = 16'($urandom);
         dir   = 8'($urandom);
         kind  = 8'($urandom);
         id    = {$urandom, $urandom};
         size  = $urandom;
         len   = $urandom_range(1, 40);
      end
      queue_frame(magic, ver, dir, kind, id, size, len);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      case (idx)
         wfhc_pkg::CSR_MAX_PAYLOAD:     lim_payload = val;
         wfhc_pkg::CSR_KIND_MIN:        kind_lo     = val[7:0];
         wfhc_pkg::CSR_KIND_MAX:        kind_hi     = val[7:0];
         wfhc_pkg::CSR_REQUIRE_REQUEST: req_only    = val[0];
         default:                       ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] lim, input logic [7:0] lo,
                             input logic [7:0] hi, input logic only_req);
      write_csr(wfhc_pkg::CSR_MAX_PAYLOAD, lim);
      write_csr(wfhc_pkg::CSR_KIND_MIN, {24'd0, lo});
      write_csr(wfhc_pkg::CSR_KIND_MAX, {24'd0, hi});
      write_csr(wfhc_pkg::CSR_REQUIRE_REQUEST, {31'd0, only_req});
      settings++;
   endtask

   // Hold off until every queued byte is taken and every owed report has come,
   // then let the block settle. Registers only change here.
   task automatic drain();
      while (byte_q.size() != 0 || req_valid || report_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- test sequence
   initial begin : sequencer
      logic [31:0] lim;
      logic [7:0]  lo;
      logic [7:0]  hi;
      int          phase_start;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames under reset register values (size limit 1 MiB, kinds 0..6)
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd0, 8'd0, 64'd1, 32'd0, 1);
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd0, 8'd0, 64'd1, 32'd0, 20);
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd1, 8'd6, '1, 32'd3, 23);
      queue_frame(32'h00534150, wfhc_pkg::WIRE_VERSION, 8'd0, 8'd0, 64'd1, 32'd0, 20);
      queue_frame(FRAME_MAGIC, 16'h0100, 8'd0, 8'd0, 64'd1, 32'd0, 20);  // version swapped
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'hFF, 8'd0, 64'd1, 32'd0, 20);
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd0, 8'd7, 64'd1, 32'd0, 20);
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd0, 8'd0, 64'd0, 32'd0, 20);
      // just over the limit, then at the limit with the length short
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd0, 8'd0, 64'd1, 32'd1048577, 20);
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd0, 8'd0, 64'd1, 32'd1048576, 20);
      // cut one byte short of the header, then one byte short of the payload
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd1, 8'd2, 64'hA5, 32'd0, 19);
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd0, 8'd3, 64'd9, 32'd2, 21);
      queue_frame(FRAME_MAGIC, 16'd0, 8'd0, 8'd200, 64'd1, 32'd0, 20);  // first failure wins
      drain();

      // Widest limits, request-only on
      set_config(32'hFFFF_FFFF, 8'd0, 8'd255, 1'b1);
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd1, 8'd255, 64'd7, 32'd0, 20);
      queue_frame(FRAME_MAGIC, wfhc_pkg::WIRE_VERSION, 8'd0, 8'd255,
                  64'h8000_0000_0000_0000, 32'd5, 25);
      drain();   // sender sits idle here until every report is back

      // Random phases, one register setting each: extremes first, then random
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_config(32'hFFFF_FFFF, 8'd0, 8'd255, 1'b0);
            1: set_config(32'd0, 8'd255, 8'd255, 1'b1);
            2: set_config(32'd8, 8'd200, 8'd10, 1'b0);   // empty kind range
            default: begin
               lim = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 16)) : $urandom;
               lo  = 8'($urandom_range(0, 255));
               hi  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(255, lo));
               set_config(lim, lo, hi, 1'($urandom_range(0, 1)));
            end
         endcase
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES)
            queue_random_frame();
         drain();
      end

      if (report_q.size() != 0) begin
         $display("%0t: %0d reports never arrived", $time, report_q.size());
         faults++;
      end
      $display("covered %0d frames, %0d bytes taken, %0d register settings",
               frames_queued, bytes_taken, settings);
      $display("reports checked %0d; per status 0..6: %0d %0d %0d %0d %0d %0d %0d", reports,
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4], status_hits[5], status_hits[6]);
      if (faults == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
